// ===== rtl/core/skil_pkg.sv =====
`timescale 1ns / 1ps

package skil_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  // window bounds must also hold the depth itself
  localparam int SPAN_W      = $clog2(TABLE_DEPTH + 1);

  // fixed field widths
  localparam int ENTRY_IDX_W = 12;
  localparam int CFG_W       = 13;
  localparam int KEY_W       = 64;
  localparam int LOC_W       = 64;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [63:0]            key_hash;
    logic [31:0]            list_offset;
    logic [31:0]            list_length;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] hit_offset;
    logic [29:0] row_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the input beat
    logic wr_en;     // write entry to the tables
    logic init;      // open search window
    logic probe;     // read the middle entry
    logic step;      // narrow the window after a compare
    logic load_out;  // move the result into the output register
    logic hit;       // result carries the probed entry
  } skil_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic count_zero;
    logic window_empty;
    logic key_eq;
    logic key_lt;
    logic mid_zero;
    logic out_free;
  } skil_sts_t;

endpackage

// ===== rtl/core/skil_ram.sv =====
`timescale 1ns / 1ps

module skil_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/skil_dp.sv =====
`timescale 1ns / 1ps

module skil_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  skil_pkg::in_item_t         in_item,
  input  logic                       cfg_we,
  input  logic [skil_pkg::CFG_W-1:0] cfg_data,
  input  skil_pkg::skil_cmd_t        cmd,
  output skil_pkg::skil_sts_t        sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output skil_pkg::out_item_t        out_item
);

  import skil_pkg::*;

  logic [CFG_W-1:0]  count_r;
  logic [SPAN_W-1:0] eff_count;
  logic [KEY_W-1:0]  key_r;
  logic [SPAN_W-1:0] lo_r;
  logic [SPAN_W-1:0] hi_r;
  logic [IDX_W-1:0]  mid_r;
  logic [SPAN_W:0]   mid_sum;
  logic [IDX_W-1:0]  mid;
  logic              wr_ok;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  key_rd;
  logic [LOC_W-1:0]  loc_rd;
  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         out_item_nxt;

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  // clamp count to the table size
  assign eff_count = (32'(count_r) > 32'(TABLE_DEPTH)) ? SPAN_W'(TABLE_DEPTH)
                                                       : SPAN_W'(count_r);

  // write port of both tables
  assign wr_ok   = 32'(in_item.entry_index) < 32'(TABLE_DEPTH);
  assign wr_addr = IDX_W'(in_item.entry_index);

  // middle of the window, rounded up
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (SPAN_W+1)'(1);
  assign mid     = mid_sum[IDX_W:1];

  skil_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.wr_en && wr_ok),
    .waddr (wr_addr),
    .wdata (in_item.key_hash),
    .re    (cmd.probe),
    .raddr (mid),
    .rdata (key_rd)
  );

  skil_ram #(
    .WIDTH (LOC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_loc_ram (
    .clk   (clk),
    .we    (cmd.wr_en && wr_ok),
    .waddr (wr_addr),
    .wdata ({in_item.list_length, in_item.list_offset}),
    .re    (cmd.probe),
    .raddr (mid),
    .rdata (loc_rd)
  );

  // search key and window
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_item.key_hash;
    end
    if (cmd.init) begin
      lo_r <= '0;
      hi_r <= eff_count - SPAN_W'(1);
    end else if (cmd.step) begin
      if (key_rd < key_r) begin
        lo_r <= SPAN_W'(mid_r) + SPAN_W'(1);
      end else begin
        hi_r <= SPAN_W'(mid_r) - SPAN_W'(1);
      end
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
  end

  // result selection
  always_comb begin
    out_item_nxt = '0;
    if (cmd.hit) begin
      out_item_nxt.found      = 1'b1;
      out_item_nxt.hit_offset = loc_rd[31:0];
      out_item_nxt.row_count  = loc_rd[63:34];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // status to the controller
  assign sts.is_lookup    = in_item.operation == OP_LOOKUP;
  assign sts.count_zero   = eff_count == '0;
  assign sts.window_empty = lo_r > hi_r;
  assign sts.key_eq       = key_rd == key_r;
  assign sts.key_lt       = key_rd < key_r;
  assign sts.mid_zero     = mid_r == '0;
  assign sts.out_free     = !out_valid_r || !out_stall;

  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending beat");

  // probe address stays inside the window
  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (SPAN_W'(mid) >= lo_r && SPAN_W'(mid) <= hi_r))
    else $error("probe outside search window");

  // an opened window never reaches past the table
  a_init_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |=> (32'(hi_r) < 32'(TABLE_DEPTH) && lo_r == '0))
    else $error("search window exceeds table");

endmodule

// ===== rtl/core/skil_ctrl.sv =====
`timescale 1ns / 1ps

module skil_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skil_pkg::skil_sts_t sts,
  output skil_pkg::skil_cmd_t cmd
);

  import skil_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   hit_r;
  logic   hit_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    cmd.hit   = hit_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          hit_nxt    = 1'b0;
          if (!sts.is_lookup) begin
            cmd.wr_en = 1'b1;
            state_nxt = S_DONE;
          end else if (sts.count_zero) begin
            state_nxt = S_DONE;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (sts.window_empty) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_eq) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (!sts.key_lt && sts.mid_zero) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  // every compare follows a probe read
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> $past(cmd.probe))
    else $error("compare without a probe read");

endmodule

// ===== rtl/core/sorted_key_index_lookup.sv =====
`timescale 1ns / 1ps
// a write beat passes through S_DONE and is acknowledged once the output register is free; a lookup
// makes P probes, P <= ceil(log2(count+1)), 13 at 4096, then passes through S_DONE the same way
// throughput: one item at a time, next item accepted once the result sits in the output register
// each probe is a registered read of the key table, then the 64-bit compare
// reset: synchronous active-low rst_n clears the controller, entry_count and output valid
// table contents are not cleared and are undefined until written
module sorted_key_index_lookup (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  skil_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output skil_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [skil_pkg::CFG_W-1:0] cfg_data
);

  import skil_pkg::*;

  skil_cmd_t cmd;
  skil_sts_t sts;

  // config beats are always taken
  assign cfg_ready = 1'b1;

  skil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  skil_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sorted_key_index_lookup_tb.sv =====
`timescale 1ns / 1ps

module sorted_key_index_lookup_tb;
  import skil_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [CFG_W-1:0] COUNT_MAX = '1;

  // one row of the directed table: either a count write or an item beat
  typedef struct packed {
    bit               is_cfg;
    logic [CFG_W-1:0] cfg_val;
    in_item_t         item;
    bit               typed;
    out_item_t        want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow copy of the index table and the entry count
  logic [63:0]      shadow_keys [TABLE_DEPTH];
  logic [31:0]      shadow_offs [TABLE_DEPTH];
  logic [31:0]      shadow_lens [TABLE_DEPTH];
  logic [CFG_W-1:0] shadow_count = '0;
  logic [63:0]      sorted_keys [TABLE_DEPTH];

  out_item_t pending_results [$];
  stim_row_t dir_rows [$];
  out_item_t front_result;
  int        err_count = 0;
  int        idle_cycles = 0;
  int        filled_len = 0;
  int        rand_items = 0;
  bit        burst_mode = 1'b0;
  int        stall_left = 0;
  int        stall_len;

  sorted_key_index_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // expected result of one beat; writes update the shadow table
  function automatic out_item_t predict_lookup(input in_item_t it);
    out_item_t   res;
    int          eff;
    int          lo;
    int          hi;
    int          mid;
    logic [63:0] k;
    res = '0;
    if (it.operation == OP_WRITE) begin
      shadow_keys[it.entry_index] = it.key_hash;
      shadow_offs[it.entry_index] = it.list_offset;
      shadow_lens[it.entry_index] = it.list_length;
      return res;
    end
    eff = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    if (eff == 0) return res;
    lo  = 0;
    hi  = eff - 1;
    mid = 0;
    // binary search, upper middle first, stop at position zero
    while (lo <= hi) begin
      mid = (lo + hi + 1) / 2;
      k   = shadow_keys[mid];
      if (k < it.key_hash) begin
        lo = mid + 1;
      end else if (k > it.key_hash) begin
        if (mid == 0) break;
        hi = mid - 1;
      end else begin
        break;
      end
    end
    if (shadow_keys[mid] == it.key_hash) begin
      res.found      = 1'b1;
      res.hit_offset = shadow_offs[mid];
      res.row_count  = shadow_lens[mid][31:2];
    end
    return res;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic in_item_t make_item(input logic op, input logic [ENTRY_IDX_W-1:0] idx,
                                         input logic [63:0] key);
    in_item_t it;
    it.operation   = op;
    it.entry_index = idx;
    it.key_hash    = key;
    it.list_offset = $urandom();
    it.list_length = $urandom();
    return it;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_W-1:0] val);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.cfg_val = val;
    r.item    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  // write rows always expect the plain acknowledgment
  function automatic stim_row_t wr_row(input logic [ENTRY_IDX_W-1:0] idx, input logic [63:0] key,
                                       input logic [31:0] off, input logic [31:0] len);
    stim_row_t r;
    r.is_cfg           = 1'b0;
    r.cfg_val          = '0;
    r.item.operation   = OP_WRITE;
    r.item.entry_index = idx;
    r.item.key_hash    = key;
    r.item.list_offset = off;
    r.item.list_length = len;
    r.typed            = 1'b1;
    r.want             = '0;
    return r;
  endfunction

  function automatic stim_row_t lk_row(input logic [63:0] key, input bit typed, input logic hit,
                                       input logic [31:0] off, input logic [29:0] rows);
    stim_row_t r;
    r.is_cfg          = 1'b0;
    r.cfg_val         = '0;
    r.item            = make_item(OP_LOOKUP, ENTRY_IDX_W'($urandom()), key);
    r.typed           = typed;
    r.want.found      = hit;
    r.want.hit_offset = off;
    r.want.row_count  = rows;
    return r;
  endfunction

  // drive one input beat and queue its expected result once accepted
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t got;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    got = predict_lookup(it);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // count register is only written with the block idle
  task automatic write_entry_count(input logic [CFG_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_count = val;
  endtask

  // fill positions 0..n-1 with ascending keys, some repeated
  task automatic load_table(input int n);
    logic [63:0] k;
    int          j;
    for (int i = 0; i < n; i++) begin
      k = {$urandom(), $urandom()};
      if (n == TABLE_DEPTH) begin
        k[63:52] = i[IDX_W-1:0];
      end else begin
        if ($urandom_range(0, 3) == 0) k = k >> $urandom_range(1, 63);
        if (i > 0 && $urandom_range(0, 9) == 0) k = sorted_keys[$urandom_range(0, i - 1)];
      end
      j = i;
      while (j > 0 && sorted_keys[j-1] > k) begin
        sorted_keys[j] = sorted_keys[j-1];
        j--;
      end
      sorted_keys[j] = k;
    end
    burst_mode = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++)
      send_beat(make_item(OP_WRITE, i[IDX_W-1:0], sorted_keys[i]), 1'b0, '0);
    if (n > filled_len) filled_len = n;
    if (n < TABLE_DEPTH) rand_items += n;
  endtask

  // ascending keys on the rightmost probe path of a full-depth window only
  task automatic load_spine();
    logic [63:0] k;
    burst_mode = ($urandom_range(0, 4) == 0);
    for (int j = 0; j < IDX_W; j++) begin
      k = {4'(j + 1), 60'({$urandom(), $urandom()})};
      send_beat(make_item(OP_WRITE, ENTRY_IDX_W'(TABLE_DEPTH - (TABLE_DEPTH >> (j + 1))), k),
                1'b0, '0);
    end
    rand_items += IDX_W;
  endtask

  // lookups whose probes stay on the spine: stored spine keys and the all-ones key
  task automatic spine_burst(input logic [CFG_W-1:0] cnt, input int n);
    int          j;
    logic [63:0] k;
    write_entry_count(cnt);
    for (int i = 0; i < n; i++) begin
      j = $urandom_range(0, IDX_W - 1);
      k = shadow_keys[TABLE_DEPTH - (TABLE_DEPTH >> (j + 1))];
      if ($urandom_range(0, 4) == 0) k = '1;
      send_beat(make_item(OP_LOOKUP, ENTRY_IDX_W'($urandom()), k), 1'b0, '0);
    end
    rand_items += n;
  endtask

  // count never reaches past the written prefix of the table
  function automatic logic [CFG_W-1:0] pick_count(input int n);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'(filled_len);
    if (r < 4) return CFG_W'($urandom_range(1, filled_len));
    return CFG_W'(n);
  endfunction

  // lookups of stored keys, near misses, extremes and random keys, with stray writes
  task automatic lookup_burst(input logic [CFG_W-1:0] cnt, input int n);
    int          eff;
    int          r;
    int          pos;
    logic [63:0] k;
    write_entry_count(cnt);
    burst_mode = ($urandom_range(0, 4) == 0);
    eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      pos = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
      k   = {$urandom(), $urandom()};
      if (r < 8) begin
        send_beat(make_item(OP_WRITE, ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), k),
                  1'b0, '0);
      end else begin
        if (eff > 0 && r < 60) k = shadow_keys[pos];
        else if (eff > 0 && r < 68) k = shadow_keys[pos] + 64'd1;
        else if (eff > 0 && r < 75) k = shadow_keys[pos] - 64'd1;
        else if (r < 85) k = r[0] ? '1 : '0;
        send_beat(make_item(OP_LOOKUP, ENTRY_IDX_W'($urandom()), k), 1'b0, '0);
      end
    end
    rand_items += n;
  endtask

  // result side back pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_len = idle_len();
      out_stall  <= (stall_len != 0);
      stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        front_result = pending_results.pop_front();
        if (out_item.found !== front_result.found)
          report_mismatch($sformatf("found %b, want %b", out_item.found, front_result.found));
        if (out_item.hit_offset !== front_result.hit_offset)
          report_mismatch($sformatf("hit_offset %h, want %h",
                                    out_item.hit_offset, front_result.hit_offset));
        if (out_item.row_count !== front_result.row_count)
          report_mismatch($sformatf("row_count %h, want %h",
                                    out_item.row_count, front_result.row_count));
      end
    end
  end

  // stop when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[sorted_key_index_lookup] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_no;
    int n;
    phase_no = 0;

    // empty table
    dir_rows.push_back(lk_row(64'd0, 1'b1, 1'b0, 32'd0, 30'd0));
    dir_rows.push_back(lk_row('1, 1'b1, 1'b0, 32'd0, 30'd0));
    // small sorted table plus the last position
    dir_rows.push_back(wr_row(12'd0, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(wr_row(12'd1, 64'd5, 32'd0, 32'd3));
    dir_rows.push_back(wr_row(12'd2, '1, 32'h1234_5678, 32'h10));
    dir_rows.push_back(wr_row(12'd4095, 64'hA5A5_A5A5_A5A5_A5A5, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
    dir_rows.push_back(cfg_row(13'd3));
    dir_rows.push_back(lk_row(64'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 30'h3FFF_FFFF));
    dir_rows.push_back(lk_row(64'd5, 1'b1, 1'b1, 32'd0, 30'd0));
    dir_rows.push_back(lk_row('1, 1'b1, 1'b1, 32'h1234_5678, 30'd4));
    // missing key between stored ones
    dir_rows.push_back(lk_row(64'd3, 1'b1, 1'b0, 32'd0, 30'd0));
    dir_rows.push_back(lk_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 32'd0, 30'd0));
    // single entry window
    dir_rows.push_back(cfg_row(13'd1));
    dir_rows.push_back(lk_row(64'd5, 1'b1, 1'b0, 32'd0, 30'd0));
    dir_rows.push_back(lk_row(64'd0, 1'b0, 1'b0, 32'd0, 30'd0));
    // break the ordering at position zero
    dir_rows.push_back(wr_row(12'd0, 64'h8000_0000_0000_0000, 32'd4, 32'd7));
    dir_rows.push_back(cfg_row(13'd3));
    dir_rows.push_back(lk_row(64'd1, 1'b1, 1'b0, 32'd0, 30'd0));
    dir_rows.push_back(lk_row(64'h8000_0000_0000_0000, 1'b0, 1'b0, 32'd0, 30'd0));
    dir_rows.push_back(lk_row(64'd5, 1'b0, 1'b0, 32'd0, 30'd0));
    dir_rows.push_back(cfg_row(13'd2));
    dir_rows.push_back(lk_row('1, 1'b0, 1'b0, 32'd0, 30'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_entry_count(dir_rows[i].cfg_val);
      else send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end
    // directed rows loaded positions 0 to 2
    filled_len = 3;

    // random phases, one of them searching the full table depth
    while (rand_items < RANDOM_ITEMS) begin
      if (phase_no == 2) begin
        load_spine();
        spine_burst(CFG_W'(TABLE_DEPTH), 30);
        spine_burst(COUNT_MAX, 20);
        spine_burst(CFG_W'($urandom_range(TABLE_DEPTH + 1, COUNT_MAX - 1)), 20);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        load_table(n);
        repeat ($urandom_range(1, 3)) lookup_burst(pick_count(n), $urandom_range(10, 40));
      end
      phase_no++;
    end
    lookup_burst('0, 10);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[sorted_key_index_lookup] OK");
    end else begin
      $display("[sorted_key_index_lookup] ERROR");
    end
    $finish;
  end

endmodule
